// ----- src/modexp_pkg.sv -----
`default_nettype none

package modexp_pkg;

    localparam int WORD_BITS_DEF = 31;

    // register indexes on the configuration port
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } t_op;

    typedef enum logic [1:0] {
        OUT_VALUE,
        OUT_ZERO,
        OUT_ACC
    } t_out_sel;

    typedef struct packed {
        t_op      op;
        logic     shift_exp;
        logic     emit;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic mm_done;
        logic exp_small;
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/modexp_modmul.sv -----
`default_nettype none

module modexp_modmul
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [WORD_BITS-1:0] i_n,
    output logic                      o_done,
    output logic      [WORD_BITS-1:0] o_p
);

    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_p;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [WORD_BITS+1:0] t_sum;
    logic [WORD_BITS+1:0] t_n1;
    logic [WORD_BITS+1:0] t_n2;
    logic [WORD_BITS+1:0] d1;
    logic [WORD_BITS+1:0] d2;
    logic [WORD_BITS-1:0] n_p;

    // interleaved multiply, multiplier msb first: p = 2p + a_bit*b, then bring below n
    always_comb begin
        t_sum = {1'b0, r_p, 1'b0} + {2'b00, (r_a[WORD_BITS-1] ? r_b : '0)};
        t_n1  = {2'b00, i_n};
        t_n2  = {1'b0, i_n, 1'b0};
        d1    = t_sum - t_n1;
        d2    = t_sum - t_n2;
        if (t_sum >= t_n2) begin
            n_p = d2[WORD_BITS-1:0];
        end else if (t_sum >= t_n1) begin
            n_p = d1[WORD_BITS-1:0];
        end else begin
            n_p = t_sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WORD_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[WORD_BITS-2:0], 1'b0};
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

// ----- src/modexp_datapath.sv -----
`default_nettype none

module modexp_datapath
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic                 i_is_last,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic      [WORD_BITS-1:0] o_result,
    output logic                      o_last_out
);

    logic [WORD_BITS-1:0] r_exp_cfg;
    logic [WORD_BITS-1:0] r_mod_cfg;
    logic [WORD_BITS-1:0] r_e;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_acc;
    logic                 r_last;
    logic                 r_dest_acc;
    logic [WORD_BITS-1:0] r_result;
    logic                 r_last_out;

    logic [WORD_BITS-1:0] one_mod;
    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_a;
    logic [WORD_BITS-1:0] mm_b;
    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_p;

    // 1 mod n, for n of at least one
    assign one_mod = {{(WORD_BITS-1){1'b0}}, (r_mod_cfg != WORD_BITS'(1))};

    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_base;
        mm_b     = r_base;
        unique case (i_cmd.op)
            OP_REDUCE: begin
                mm_start = 1'b1;
                mm_b     = one_mod;
            end
            OP_MUL: begin
                mm_start = 1'b1;
                mm_a     = r_acc;
            end
            OP_SQR: begin
                mm_start = 1'b1;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    modexp_modmul #(
        .WORD_BITS(WORD_BITS)
    ) u_modmul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mm_start),
        .i_a    (mm_a),
        .i_b    (mm_b),
        .i_n    (r_mod_cfg),
        .o_done (mm_done),
        .o_p    (mm_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cfg <= WORD_BITS'(1);
            r_mod_cfg <= WORD_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EXPONENT: r_exp_cfg <= i_cfg_data;
                REG_MODULUS:  r_mod_cfg <= i_cfg_data;
                default:      r_exp_cfg <= r_exp_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mm_done) begin
            if (r_dest_acc) begin
                r_acc <= mm_p;
            end else begin
                r_base <= mm_p;
            end
        end
        if (i_cmd.op == OP_LOAD) begin
            r_base <= i_value;
            r_last <= i_is_last;
            r_e    <= r_exp_cfg;
            r_acc  <= one_mod;
        end
        if (mm_start) begin
            r_dest_acc <= (i_cmd.op == OP_MUL);
        end
        if (i_cmd.shift_exp) begin
            r_e <= {1'b0, r_e[WORD_BITS-1:1]};
        end
        if (i_cmd.emit) begin
            r_last_out <= r_last;
            unique case (i_cmd.out_sel)
                OUT_VALUE: r_result <= r_base;
                OUT_ZERO:  r_result <= '0;
                OUT_ACC:   r_result <= r_acc;
                default:   r_result <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.mm_done   = mm_done;
        o_stat.exp_small = (r_e[WORD_BITS-1:1] == '0);
        o_stat.exp_zero  = (r_e == '0);
        o_stat.exp_lsb   = r_e[0];
        o_stat.mod_zero  = (r_mod_cfg == '0);
    end

    assign o_result   = r_result;
    assign o_last_out = r_last_out;

endmodule

`default_nettype wire

// ----- src/modexp_ctrl.sv -----
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RED,
        S_STEP,
        S_MUL,
        S_SQR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state         = r_state;
        n_valid         = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.shift_exp = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.out_sel   = OUT_ACC;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.exp_small) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.out_sel = OUT_VALUE;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.mod_zero) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.out_sel = OUT_ZERO;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.op = OP_REDUCE;
                    n_state  = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                priority if (i_stat.exp_zero) begin
                    o_cmd.emit = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.op = OP_MUL;
                    n_state  = S_MUL;
                end else begin
                    o_cmd.op = OP_SQR;
                    n_state  = S_SQR;
                end
            end
            S_MUL: begin
                if (i_stat.mm_done) begin
                    o_cmd.op = OP_SQR;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                if (i_stat.mm_done) begin
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ----- src/modular_exponentiation.sv -----
// one element at a time; start is taken while busy is low, also in the strobe cycle
// exponent below 2 or modulus zero: the result is decided in the check state, with no multiply
// otherwise the base is reduced mod n, then the exponent is scanned lsb first with a multiply
// for each set bit and a square for each bit; one bit-serial modular multiplier does
// every multiply and reduction, one multiplier bit per cycle
// synchronous active-low reset idles the block and sets exponent and modulus to 1
`default_nettype none

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic                 i_is_last,
    output logic                      o_valid,
    output logic      [WORD_BITS-1:0] o_result,
    output logic                      o_last_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    modexp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy),
        .o_valid(o_valid)
    );

    modexp_datapath #(
        .WORD_BITS(WORD_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_value   (i_value),
        .i_is_last (i_is_last),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_result  (o_result),
        .o_last_out(o_last_out)
    );

endmodule

`default_nettype wire

// ----- src/modexp_checker.sv -----
`default_nettype none

module modexp_props (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // an accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start transaction did not raise busy");

    // the result strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result is shown only once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // finishing a transaction always gives a result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind modular_exponentiation modexp_props u_modexp_props (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid)
);

`default_nettype wire
